// File: design/plft_pkg.sv
// Package: shared types, codes and decode functions for the fan triangulator.
`timescale 1ns / 1ps
package plft_pkg;

	localparam int unsigned ADDR_W = 4;

	// integer encoding codes
	localparam logic [2:0] ENC_I8  = 3'd0;
	localparam logic [2:0] ENC_U8  = 3'd1;
	localparam logic [2:0] ENC_I16 = 3'd2;
	localparam logic [2:0] ENC_U16 = 3'd3;
	localparam logic [2:0] ENC_I32 = 3'd4;
	localparam logic [2:0] ENC_U32 = 3'd5;

	// register indexes
	localparam logic [1:0] REG_COUNT_TYPE = 2'd0;
	localparam logic [1:0] REG_INDEX_TYPE = 2'd1;
	localparam logic [1:0] REG_FACE_TOTAL = 2'd2;
	localparam logic [1:0] REG_TRAILING   = 2'd3;

	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_INDEX = 2'd1,
		PH_SKIP  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_mesh;
	} in_t;

	typedef struct packed {
		logic signed [31:0] first_vertex;
		logic signed [31:0] second_vertex;
		logic signed [31:0] third_vertex;
		logic [30:0]        face_number;
		logic               last_of_face;
	} out_t;

	typedef struct packed {
		logic [2:0]  count_type;
		logic [2:0]  index_type;
		logic [30:0] face_total;
		logic [7:0]  trailing_bytes;
	} cfg_t;

	// byte position at which a value of this encoding is complete
	function automatic logic [1:0] enc_last_pos(input logic [2:0] code);
		logic [1:0] pos;
		case (code) inside
			ENC_I8, ENC_U8:   pos = 2'd0;
			ENC_I16, ENC_U16: pos = 2'd1;
			default:          pos = 2'd3;
		endcase
		return pos;
	endfunction

	function automatic logic [31:0] enc_extend(input logic [31:0] raw, input logic [2:0] code);
		logic [31:0] v;
		case (code)
			ENC_I8:  v = {{24{raw[7]}}, raw[7:0]};
			ENC_U8:  v = {24'd0, raw[7:0]};
			ENC_I16: v = {{16{raw[15]}}, raw[15:0]};
			ENC_U16: v = {16'd0, raw[15:0]};
			default: v = raw;
		endcase
		return v;
	endfunction

endpackage

// File: design/plft_regs.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module plft_regs import plft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_type     <= ENC_U8;
			cfg_q.index_type     <= ENC_I32;
			cfg_q.face_total     <= '0;
			cfg_q.trailing_bytes <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_COUNT_TYPE: cfg_q.count_type     <= pwdata[2:0];
				REG_INDEX_TYPE: cfg_q.index_type     <= pwdata[2:0];
				REG_FACE_TOTAL: cfg_q.face_total     <= pwdata[30:0];
				REG_TRAILING:   cfg_q.trailing_bytes <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COUNT_TYPE: prdata = {29'd0, cfg_q.count_type};
			REG_INDEX_TYPE: prdata = {29'd0, cfg_q.index_type};
			REG_FACE_TOTAL: prdata = {1'b0, cfg_q.face_total};
			REG_TRAILING:   prdata = {24'd0, cfg_q.trailing_bytes};
			default:        prdata = '0;
		endcase
	end

endmodule

// File: design/polygon_list_fan_triangulator.sv
// Top level: byte stream face list decoder with fan triangulation.
// Path: an accepted byte passes the input register, and its triangle is then held in the result register.
// Throughput: one byte per cycle while the result register is not stalled, set by the single face-state update stage.
// Stall: the input stalls only while a byte waits behind a stalled result register.
// Reset: arst_n clears face progress, both stages and the registers to defaults.
`timescale 1ns / 1ps
module polygon_list_fan_triangulator import plft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  in_t               src_data,
	output logic              res_valid,
	input  logic              res_stall,
	output out_t              res_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;

	plft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic valid_s1;
	in_t  data_s1;
	logic advance;
	logic res_valid_q;

	assign advance   = valid_s1 & (~res_valid_q | ~res_stall);
	assign src_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			data_s1 <= src_data;
		end
	end

	// face state
	phase_t      phase_q, c_phase, n_phase;
	logic [1:0]  bpos_q, c_bpos, n_bpos;
	logic [31:0] asm_q, c_asm, n_asm;
	logic [31:0] nvert_q, c_nvert, n_nvert;
	logic [31:0] idx_q, c_idx, n_idx;
	logic [31:0] apex_q, c_apex, n_apex;
	logic [31:0] prev_q, c_prev, n_prev;
	logic [30:0] faces_q, c_faces, n_faces;
	logic [7:0]  skip_q, c_skip, n_skip;

	logic        emit;
	out_t        res_n;
	out_t        res_q;

	logic [2:0]  code;
	logic [31:0] asm_v;
	logic [31:0] value;
	logic [31:0] idx_inc;
	logic        clr;
	logic        list_end;

	always_comb begin
		clr     = data_s1.start_of_mesh;
		c_phase = clr ? PH_COUNT : phase_q;
		c_bpos  = clr ? 2'd0 : bpos_q;
		c_asm   = clr ? 32'd0 : asm_q;
		c_nvert = clr ? 32'd0 : nvert_q;
		c_idx   = clr ? 32'd0 : idx_q;
		c_apex  = clr ? 32'd0 : apex_q;
		c_prev  = clr ? 32'd0 : prev_q;
		c_faces = clr ? 31'd0 : faces_q;
		c_skip  = clr ? 8'd0 : skip_q;

		n_phase = c_phase;
		n_bpos  = c_bpos;
		n_asm   = c_asm;
		n_nvert = c_nvert;
		n_idx   = c_idx;
		n_apex  = c_apex;
		n_prev  = c_prev;
		n_faces = c_faces;
		n_skip  = c_skip;

		code     = (c_phase == PH_INDEX) ? cfg.index_type : cfg.count_type;
		asm_v    = c_asm | ({24'd0, data_s1.data_byte} << {c_bpos, 3'b000});
		value    = enc_extend(asm_v, code);
		idx_inc  = c_idx + 32'd1;
		list_end = 1'b0;
		emit     = 1'b0;

		res_n.first_vertex  = c_apex;
		res_n.second_vertex = c_prev;
		res_n.third_vertex  = value;
		res_n.face_number   = c_faces;
		res_n.last_of_face  = (idx_inc == c_nvert);

		if (c_faces < cfg.face_total) begin
			if (c_phase == PH_SKIP) begin
				n_skip = c_skip - 8'd1;
				if (n_skip == 8'd0) begin
					n_faces = c_faces + 31'd1;
					n_phase = PH_COUNT;
					n_idx   = '0;
					n_nvert = '0;
				end
			end else if (c_bpos < enc_last_pos(code)) begin
				n_bpos = c_bpos + 2'd1;
				n_asm  = asm_v;
			end else begin
				n_bpos = '0;
				n_asm  = '0;
				if (c_phase != PH_INDEX) begin
					if (value == 32'd0 || value[31]) begin
						list_end = 1'b1;
					end else begin
						n_nvert = value;
						n_idx   = '0;
						n_phase = PH_INDEX;
					end
				end else begin
					if (c_idx == 32'd0) begin
						n_apex = value;
					end
					emit   = (c_idx >= 32'd2);
					n_prev = value;
					n_idx  = idx_inc;
					list_end = (idx_inc >= c_nvert);
				end
				if (list_end) begin
					if (cfg.trailing_bytes != 8'd0) begin
						n_skip  = cfg.trailing_bytes;
						n_phase = PH_SKIP;
					end else begin
						n_faces = c_faces + 31'd1;
						n_phase = PH_COUNT;
						n_idx   = '0;
						n_nvert = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			bpos_q  <= '0;
			asm_q   <= '0;
			nvert_q <= '0;
			idx_q   <= '0;
			apex_q  <= '0;
			prev_q  <= '0;
			faces_q <= '0;
			skip_q  <= '0;
		end else if (advance) begin
			phase_q <= n_phase;
			bpos_q  <= n_bpos;
			asm_q   <= n_asm;
			nvert_q <= n_nvert;
			idx_q   <= n_idx;
			apex_q  <= n_apex;
			prev_q  <= n_prev;
			faces_q <= n_faces;
			skip_q  <= n_skip;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// File: design/plft_chk.sv
// Port-level checker for the fan triangulator, bound to the top level.
`timescale 1ns / 1ps
module plft_chk import plft_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic src_stall,
	input logic res_valid,
	input logic res_stall,
	input out_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> res_valid && res_stall)
		else $error("input stalled without a stalled result");

	a_fell_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(!res_stall))
		else $error("result withdrawn before it was taken");

endmodule

bind polygon_list_fan_triangulator plft_chk u_plft_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
